/* src/lzp_pkg.sv */
// lzp_pkg: shared types and constants for the lz pair bit packer
// no dependencies; imported by every module of the block

package lzp_pkg;

  localparam int CODE_BITS   = 16;
  localparam int SYM_BITS    = 8;
  localparam int BYTE_BITS   = 8;
  localparam int WIDTH_BITS  = 5;
  localparam int CNT_BITS    = 3;
  localparam int PEND_BITS   = 7;
  localparam int WORD_BITS   = CODE_BITS + SYM_BITS;
  localparam int ACC_BITS    = WORD_BITS + PEND_BITS;
  localparam int REM_BITS    = 2;

  localparam int MAX_CODE_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF   = 4;

  localparam logic FUNC_PACK  = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  typedef struct packed {
    logic                  func;
    logic [CODE_BITS-1:0]  code;
    logic [SYM_BITS-1:0]   sym;
    logic [WIDTH_BITS-1:0] code_width;
  } req_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] out_byte;
    logic                 out_last;
  } rsp_t;

  // classified item held in the queue between front and back
  typedef struct packed {
    logic                  flush;
    logic [WIDTH_BITS-1:0] width;
    logic [WORD_BITS-1:0]  word;
  } entry_t;

endpackage

/* src/lzp_front.sv */
// lzp_front: classifies an incoming transaction and builds the packed word
// depends on lzp_pkg

module lzp_front import lzp_pkg::*; #(
  parameter int MaxCodeBits = MAX_CODE_BITS_DEF
) (
  input  req_t   req,
  output entry_t entry
);

  localparam int EffMax = (MaxCodeBits < CODE_BITS) ? MaxCodeBits : CODE_BITS;

  logic [WIDTH_BITS-1:0] width;
  logic [CODE_BITS-1:0]  code_mask;
  logic [WORD_BITS-1:0]  code_ext;
  logic [WORD_BITS-1:0]  sym_ext;

  always_comb begin
    width = req.code_width;
    if (width > WIDTH_BITS'(EffMax)) begin
      width = WIDTH_BITS'(EffMax);
    end
    // width never exceeds the code field, so a full shift leaves an all-ones mask
    code_mask = ~({CODE_BITS{1'b1}} << width);
    code_ext  = {{SYM_BITS{1'b0}}, req.code & code_mask};
    sym_ext   = {{CODE_BITS{1'b0}}, req.sym};

    entry.flush = (req.func == FUNC_FLUSH);
    entry.width = width;
    entry.word  = code_ext | (sym_ext << width);
  end

endmodule

/* src/lzp_fifo.sv */
// lzp_fifo: short queue of classified entries between front and back
// depends on lzp_pkg

module lzp_fifo import lzp_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output entry_t head
);

  localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntBits = $clog2(Depth + 1);

  entry_t               mem [Depth];
  logic [PtrBits-1:0]   wr_ptr;
  logic [PtrBits-1:0]   rd_ptr;
  logic [CntBits-1:0]   fill;
  logic                 do_push;
  logic                 do_pop;

  assign full      = (fill == CntBits'(Depth));
  assign not_empty = (fill != '0);
  assign head      = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrBits'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrBits'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (!do_push && do_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* src/lzp_back.sv */
// lzp_back: merges entries with the pending bits and emits one byte per cycle unless the output is stalled
// depends on lzp_pkg

module lzp_back import lzp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   q_valid,
  input  entry_t q_entry,
  output logic   q_pop,
  output logic   rsp_valid,
  input  logic   rsp_stall,
  output rsp_t   rsp
);

  // acc low bits hold the pending bits once rem reaches zero; bits above are zero
  logic [ACC_BITS-1:0]   acc;
  logic [REM_BITS-1:0]   rem;
  logic [CNT_BITS-1:0]   cnt;
  logic                  out_valid;
  rsp_t                  out_item;

  logic [ACC_BITS-1:0]   acc_sh;
  logic [REM_BITS-1:0]   rem_sh;
  logic                  advance;
  logic                  emit;
  logic [WIDTH_BITS-1:0] total;
  logic [ACC_BITS-1:0]   acc_next;
  logic [REM_BITS-1:0]   rem_next;
  logic [CNT_BITS-1:0]   cnt_next;

  assign rsp_valid = out_valid;
  assign rsp       = out_item;

  always_comb begin
    advance = !out_valid || !rsp_stall;
    emit    = advance && (rem != '0);
    acc_sh  = emit ? (acc >> BYTE_BITS) : acc;
    rem_sh  = emit ? (rem - 1'b1) : rem;
    q_pop   = q_valid && (rem_sh == '0);

    total = WIDTH_BITS'(cnt) + q_entry.width + WIDTH_BITS'(BYTE_BITS);

    acc_next = acc_sh;
    rem_next = rem_sh;
    cnt_next = cnt;
    if (q_pop) begin
      if (q_entry.flush) begin
        acc_next = {{(ACC_BITS-PEND_BITS){1'b0}}, acc_sh[PEND_BITS-1:0]};
        rem_next = (cnt != '0) ? REM_BITS'(1) : '0;
        cnt_next = '0;
      end else begin
        acc_next = {{(ACC_BITS-PEND_BITS){1'b0}}, acc_sh[PEND_BITS-1:0]}
                 | (ACC_BITS'(q_entry.word) << cnt);
        rem_next = total[WIDTH_BITS-1:CNT_BITS];
        cnt_next = total[CNT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      rem       <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      acc <= acc_next;
      rem <= rem_next;
      cnt <= cnt_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (advance) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item.out_byte <= acc[BYTE_BITS-1:0];
      out_item.out_last <= (rem == REM_BITS'(1));
    end
  end

endmodule

/* src/lz_pair_bit_packer_core.sv */
// lz_pair_bit_packer_core: top level of the lsb-first (code, symbol) bit packer
// depends on lzp_pkg, lzp_front, lzp_fifo, lzp_back
//
//   channel  | dir | handshake            | payload
//   req      | in  | req_valid/req_stall  | req_t: func, code, sym, code_width
//   rsp      | out | rsp_valid/rsp_stall  | rsp_t: out_byte, out_last
//
// each pack transaction completes 1 to 3 bytes, which leave one at a time through
// the single byte-wide output register; a flush completes at most one byte
// an accepted transaction passes through the queue and the back end's accumulator
// before its first byte is loaded into the output register
// reset clears the queue, the pending bits and the output valid flag
// a stalled output keeps its byte; the queue keeps accepting until it is full

module lz_pair_bit_packer_core import lzp_pkg::*; #(
  parameter int MaxCodeBits = MAX_CODE_BITS_DEF,
  parameter int QueueDepth  = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  entry_t front_entry;
  entry_t q_head;
  logic   q_full;
  logic   q_valid;
  logic   q_pop;

  assign req_stall = q_full;

  lzp_front #(
    .MaxCodeBits(MaxCodeBits)
  ) u_front (
    .req  (req),
    .entry(front_entry)
  );

  lzp_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (req_valid),
    .push_entry(front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  lzp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_entry  (q_head),
    .q_pop    (q_pop),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

endmodule

/* src/lzp_checker.sv */
// lzp_checker: port-level checks on the bit packer, bound to the top level
// depends on lzp_pkg and lz_pair_bit_packer_core

module lzp_checker import lzp_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // a stalled byte stays valid and unchanged
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled output byte changed");

  // bytes of one transaction follow each other without a gap
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_stall && !rsp.out_last |=> rsp_valid)
    else $error("gap inside a multi-byte transaction");

  a_rsp_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !rsp_valid)
    else $error("output valid right after reset");

  // queue is empty after reset, so the input is open
  a_req_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !req_stall)
    else $error("input stalled right after reset");

endmodule

bind lz_pair_bit_packer_core lzp_checker u_lzp_checker (.*);
